FILE: sv/hsra_pkg.sv
// Package for the heap slot range allocator.
// Shared types and constants; no dependencies.
package hsra_pkg;

  // Heap count and slot count are tied to the 2-bit heap and 10-bit slot fields.
  localparam int unsigned MAX_HEAPS = 4;
  localparam int unsigned MAX_SLOTS = 1024;

  localparam int unsigned KIND_ALLOC = 0;
  localparam int unsigned KIND_FREE  = 1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_HEAP  = 2'd1,
    ST_NOT_OPEN = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } fsm_t;

  localparam logic CFG_SLOTS = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  // Per-cycle command broadcast to every range cell of the selected heap.
  typedef enum logic [2:0] {
    C_NONE,
    C_SHIFT_UP,
    C_SHIFT_DOWN,
    C_LOAD,
    C_SET_BEGIN,
    C_SET_LIMIT
  } cmd_op_t;

endpackage

FILE: sv/hsra_cell.sv
// One range cell: holds a [begin, limit) pair of one heap's free list.
// Depends on hsra_pkg. Cells form a chain and shift entries to neighbors.
module hsra_cell #(
  parameter int unsigned VW = 11
) (
  input  logic              clk,
  input  logic              en,        // this cell takes the command
  input  hsra_pkg::cmd_op_t op,
  input  logic [VW-1:0]     ld_begin,
  input  logic [VW-1:0]     ld_limit,
  input  logic [VW-1:0]     up_begin,  // from lower neighbor
  input  logic [VW-1:0]     up_limit,
  input  logic [VW-1:0]     dn_begin,  // from upper neighbor
  input  logic [VW-1:0]     dn_limit,
  output logic [VW-1:0]     q_begin,
  output logic [VW-1:0]     q_limit
);

  logic [VW-1:0] begin_r, limit_r, begin_nxt, limit_nxt;

  always_comb begin
    begin_nxt = begin_r;
    limit_nxt = limit_r;
    if (en) begin
      unique case (op)
        hsra_pkg::C_SHIFT_UP: begin
          begin_nxt = up_begin;
          limit_nxt = up_limit;
        end
        hsra_pkg::C_SHIFT_DOWN: begin
          begin_nxt = dn_begin;
          limit_nxt = dn_limit;
        end
        hsra_pkg::C_LOAD: begin
          begin_nxt = ld_begin;
          limit_nxt = ld_limit;
        end
        hsra_pkg::C_SET_BEGIN: begin_nxt = ld_begin;
        hsra_pkg::C_SET_LIMIT: limit_nxt = ld_limit;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    begin_r <= begin_nxt;
    limit_r <= limit_nxt;
  end

  assign q_begin = begin_r;
  assign q_limit = limit_r;

endmodule

FILE: sv/heap_slot_range_allocator_unit.sv
// Top level of the heap slot range allocator: control sequencer plus a
// chain of hsra_cell range cells per heap. Depends on hsra_pkg, hsra_cell.
//
//  channel | direction | tdata / payload
//  in_     | slave     | {slot_index[12:3], heap_index[2:1], kind[0]}
//  out_    | master    | {granted_slot[13:4], granted_heap[3:2], status[1:0]}
//  cfg_    | slave     | index 0 slots_per_heap, 1 heap_limit
//
// One request at a time. An allocate walks the open heaps one per cycle (up to
// MAX_HEAPS), then either takes a load step for a newly opened heap or, when
// the front range empties, shifts the chain down. A free first checks the
// heap, then scans cells one per cycle and on an insert shifts the chain up
// one cell per cycle before it loads the new range at the insert position.
// Reset (rst_n, synchronous) clears heap count, range counts and control;
// range cells are not cleared. in_tready drops while busy; a result waits in
// the output register until out_tready, and the next beat is taken in the
// idle cycle after it leaves.
module heap_slot_range_allocator_unit #(
  parameter int unsigned MAX_RANGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // kind[0], heap_index[2:1], slot_index[12:3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status[1:0], granted_heap[3:2], granted_slot[13:4]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int unsigned HW = (hsra_pkg::MAX_HEAPS > 1) ? $clog2(hsra_pkg::MAX_HEAPS) : 1;
  localparam int unsigned OW = $clog2(hsra_pkg::MAX_HEAPS + 1);
  localparam int unsigned RW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned VW = 11;

  // configuration
  logic [10:0] sph_r;
  logic [2:0]  hlim_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sph_r  <= 11'd1024;
      hlim_r <= 3'd4;
    end else if (cfg_valid) begin
      if (cfg_index == hsra_pkg::CFG_SLOTS) sph_r <= cfg_data;
      else hlim_r <= cfg_data[2:0];
    end
  end

  // request registers
  hsra_pkg::fsm_t  st_r, st_nxt;
  logic            kind_r;
  logic [1:0]      hreq_r;
  logic [9:0]      sreq_r;
  logic [HW-1:0]   h_r, h_nxt;      // heap being worked on
  logic [CW-1:0]   i_r, i_nxt;      // scan / shift position
  logic [CW-1:0]   pos_r, pos_nxt;  // insert position
  logic [OW-1:0]   open_r, open_nxt;
  logic [CW-1:0]   cnt_r [hsra_pkg::MAX_HEAPS];
  logic [CW-1:0]   cnt_nxt;
  logic            cnt_we;
  logic [1:0]      ost_r, ost_nxt;
  logic [1:0]      ogh_r, ogh_nxt;
  logic [9:0]      ogs_r, ogs_nxt;

  // cell array
  logic [VW-1:0] qb [hsra_pkg::MAX_HEAPS][MAX_RANGES];
  logic [VW-1:0] ql [hsra_pkg::MAX_HEAPS][MAX_RANGES];
  hsra_pkg::cmd_op_t op;
  logic [MAX_RANGES-1:0] cell_en;
  logic [VW-1:0] ld_b, ld_l;

  for (genvar h = 0; h < hsra_pkg::MAX_HEAPS; h++) begin : g_heap
    for (genvar c = 0; c < MAX_RANGES; c++) begin : g_cell
      localparam int unsigned CU = (c == 0) ? 0 : c - 1;
      localparam int unsigned CD = (c == MAX_RANGES - 1) ? c : c + 1;
      hsra_cell #(.VW(VW)) u_cell (
        .clk      (clk),
        .en       (cell_en[c] && (h_r == HW'(h))),
        .op       (op),
        .ld_begin (ld_b),
        .ld_limit (ld_l),
        .up_begin (qb[h][CU]),
        .up_limit (ql[h][CU]),
        .dn_begin (qb[h][CD]),
        .dn_limit (ql[h][CD]),
        .q_begin  (qb[h][c]),
        .q_limit  (ql[h][c])
      );
    end
  end

  // current cell read: front cell and scan cell of the chosen heap
  logic [VW-1:0] fb, fl, sb, sl;
  logic [RW-1:0] iidx;
  assign iidx = i_r[RW-1:0];
  assign fb = qb[h_r][0];
  assign fl = ql[h_r][0];
  assign sb = qb[h_r][iidx];
  assign sl = ql[h_r][iidx];

  logic [VW-1:0] s_ext, s_p1, fb_p1, n_open;
  logic [3:0]    lim_eff;
  assign s_ext = VW'(sreq_r);
  assign s_p1  = s_ext + VW'(1);
  assign fb_p1 = fb + VW'(1);
  assign lim_eff = (hlim_r > 3'(hsra_pkg::MAX_HEAPS)) ? 4'(hsra_pkg::MAX_HEAPS)
                                                       : 4'(hlim_r);
  assign n_open = (sph_r == '0) ? VW'(1)
                : (32'(sph_r) > hsra_pkg::MAX_SLOTS) ? VW'(hsra_pkg::MAX_SLOTS) : sph_r;

  logic [CW-1:0] cur_cnt;
  assign cur_cnt = cnt_r[h_r];

  always_comb begin
    st_nxt   = st_r;
    h_nxt    = h_r;
    i_nxt    = i_r;
    pos_nxt  = pos_r;
    open_nxt = open_r;
    cnt_nxt  = cur_cnt;
    cnt_we   = 1'b0;
    ost_nxt  = ost_r;
    ogh_nxt  = ogh_r;
    ogs_nxt  = ogs_r;
    op       = hsra_pkg::C_NONE;
    cell_en  = '0;
    ld_b     = fb_p1;
    ld_l     = fl;
    unique case (st_r)
      hsra_pkg::S_IDLE: begin
        // in_tready is high here, so a valid beat is taken
        if (in_tvalid) begin
          st_nxt  = hsra_pkg::S_FIND;
          h_nxt   = '0;
          ost_nxt = hsra_pkg::ST_OK;
          ogh_nxt = '0;
          ogs_nxt = '0;
        end
      end
      hsra_pkg::S_FIND: begin
        if (kind_r == 1'(hsra_pkg::KIND_ALLOC)) begin
          // walk heaps one per cycle
          if (32'(h_r) < 32'(open_r) && cur_cnt != '0) begin
            ost_nxt = hsra_pkg::ST_OK;
            ogh_nxt = 2'(h_r);
            ogs_nxt = 10'(fb);
            op = hsra_pkg::C_SET_BEGIN;
            cell_en[0] = 1'b1;
            if (fb_p1 >= fl) begin
              i_nxt  = CW'(1);
              st_nxt = hsra_pkg::S_SHIFT;
            end else st_nxt = hsra_pkg::S_DONE;
          end else if (32'(h_r) + 1 < 32'(open_r)) begin
            h_nxt = h_r + HW'(1);
          end else if (32'(open_r) >= 32'(lim_eff)) begin
            ost_nxt = hsra_pkg::ST_NO_HEAP;
            ogh_nxt = '0;
            ogs_nxt = '0;
            st_nxt  = hsra_pkg::S_DONE;
          end else begin
            // open a new heap, grant slot 0
            h_nxt    = HW'(open_r);
            open_nxt = open_r + OW'(1);
            st_nxt   = hsra_pkg::S_SCAN;   // load step
          end
        end else begin
          if (32'(hreq_r) >= 32'(open_r)) begin
            ost_nxt = hsra_pkg::ST_NOT_OPEN;
            st_nxt  = hsra_pkg::S_DONE;
          end else begin
            h_nxt  = HW'(hreq_r);
            i_nxt  = '0;
            st_nxt = hsra_pkg::S_SCAN;
          end
        end
      end
      hsra_pkg::S_SCAN: begin
        if (kind_r == 1'(hsra_pkg::KIND_ALLOC)) begin
          // new heap: first range [1,n) or empty when n == 1
          ost_nxt = hsra_pkg::ST_OK;
          ogh_nxt = 2'(h_r);
          ogs_nxt = '0;
          op = hsra_pkg::C_LOAD;
          cell_en[0] = 1'b1;
          ld_b = VW'(1);
          ld_l = n_open;
          cnt_we  = 1'b1;
          cnt_nxt = (n_open == VW'(1)) ? '0 : CW'(1);
          st_nxt  = hsra_pkg::S_DONE;
        end else if (i_r < cur_cnt && sb == s_p1) begin
          op = hsra_pkg::C_SET_BEGIN;
          cell_en[iidx] = 1'b1;
          ld_b = s_ext;
          ost_nxt = hsra_pkg::ST_OK;
          st_nxt  = hsra_pkg::S_DONE;
        end else if (i_r < cur_cnt && sl == s_ext) begin
          op = hsra_pkg::C_SET_LIMIT;
          cell_en[iidx] = 1'b1;
          ld_l = s_p1;
          ost_nxt = hsra_pkg::ST_OK;
          st_nxt  = hsra_pkg::S_DONE;
        end else if (i_r < cur_cnt && !(sb > s_ext)) begin
          i_nxt = i_r + CW'(1);
        end else if (32'(cur_cnt) >= MAX_RANGES) begin
          ost_nxt = hsra_pkg::ST_FULL;
          st_nxt  = hsra_pkg::S_DONE;
        end else begin
          pos_nxt = i_r;
          i_nxt   = cur_cnt;
          ost_nxt = hsra_pkg::ST_OK;
          st_nxt  = hsra_pkg::S_SHIFT;
        end
      end
      hsra_pkg::S_SHIFT: begin
        if (kind_r == 1'(hsra_pkg::KIND_ALLOC)) begin
          // drop front: cell i-1 takes cell i
          if (i_r < cur_cnt) begin
            op = hsra_pkg::C_SHIFT_DOWN;
            cell_en[RW'(i_r - CW'(1))] = 1'b1;
            i_nxt = i_r + CW'(1);
          end else begin
            cnt_we  = 1'b1;
            cnt_nxt = cur_cnt - CW'(1);
            st_nxt  = hsra_pkg::S_DONE;
          end
        end else begin
          // insert: shift up from the top, then load at pos
          if (i_r > pos_r) begin
            op = hsra_pkg::C_SHIFT_UP;
            cell_en[iidx] = 1'b1;
            i_nxt = i_r - CW'(1);
          end else begin
            op = hsra_pkg::C_LOAD;
            cell_en[iidx] = 1'b1;
            ld_b = s_ext;
            ld_l = s_p1;
            cnt_we  = 1'b1;
            cnt_nxt = cur_cnt + CW'(1);
            st_nxt  = hsra_pkg::S_DONE;
          end
        end
      end
      hsra_pkg::S_DONE: begin
        if (out_tready) st_nxt = hsra_pkg::S_IDLE;
      end
      default: st_nxt = hsra_pkg::S_IDLE;
    endcase
  end

  assign in_tready  = (st_r == hsra_pkg::S_IDLE);
  assign out_tvalid = (st_r == hsra_pkg::S_DONE);
  assign out_tdata  = {2'b00, ogs_r, ogh_r, ost_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= hsra_pkg::S_IDLE;
      open_r <= '0;
      for (int k = 0; k < hsra_pkg::MAX_HEAPS; k++) cnt_r[k] <= '0;
    end else begin
      st_r   <= st_nxt;
      open_r <= open_nxt;
      if (cnt_we) cnt_r[h_r] <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r   <= h_nxt;
    i_r   <= i_nxt;
    pos_r <= pos_nxt;
    ost_r <= ost_nxt;
    ogh_r <= ogh_nxt;
    ogs_r <= ogs_nxt;
    if (in_tvalid && in_tready) begin
      kind_r <= in_tdata[0];
      hreq_r <= in_tdata[2:1];
      sreq_r <= in_tdata[12:3];
    end
  end

endmodule
